// File: hdl/lai_pkg.sv
// Shared constants, widths and records of the linear and angle interpolator.
package lai_pkg;

	localparam int FRAC_BITS = 16;
	localparam int W         = 32;

	// pi with 48 fraction bits, rounded to nearest at FRAC_BITS
	localparam logic [63:0] PI_Q48    = 64'h0003_243F_6A88_85A3;
	localparam logic [63:0] PI_FIX64  =
		(PI_Q48 + (64'd1 << (47 - FRAC_BITS))) >> (48 - FRAC_BITS);
	localparam logic [63:0] TWO_PI64  = PI_FIX64 << 1;

	localparam logic signed [W:0] PI_D     = $signed({1'b0, PI_FIX64[W-1:0]});
	localparam logic signed [W:0] TWO_PI_D = $signed({1'b0, TWO_PI64[W-1:0]});

	// angle wrap: signed input of WX bits, biased unsigned work word of UW bits
	localparam int WX     = 36;
	localparam int UW     = 40;
	localparam int WN     = $clog2((64'd1 << WX) / TWO_PI64);
	localparam int WSTEPS = WN + 1;
	localparam logic [UW-1:0] PI_U     = PI_FIX64[UW-1:0];
	localparam logic [UW-1:0] TWO_PI_U = TWO_PI64[UW-1:0];
	localparam logic [UW-1:0] OFS_U    = TWO_PI_U << WN;

	// ratio divider
	localparam int DENW = W;
	localparam int NW   = W + 1 + FRAC_BITS;
	localparam int QB   = W + 1;
	localparam logic [QB-1:0] RMAG_NEG = QB'(64'd1 << (W - 1));
	localparam logic [QB-1:0] RMAG_POS = RMAG_NEG - QB'(1);

	// delta * ratio
	localparam int MSPLIT = 16;
	localparam int PLO_W  = MSPLIT + W;
	localparam int PHI_W  = W + 1 - MSPLIT + W;
	localparam int PW     = 64;
	localparam int QW     = PW - FRAC_BITS;
	localparam int SW     = QW + 2;
	localparam logic [PW-1:0] HALF = PW'(64'd1 << (FRAC_BITS - 1));

	localparam int FIFO_DEPTH = 4;
	localparam int FPW        = $clog2(FIFO_DEPTH);
	localparam int FCW        = $clog2(FIFO_DEPTH + 1);

	typedef struct packed {
		logic                kind;
		logic                degen;
		logic signed [W:0]   dq;
		logic signed [W:0]   dx;
		logic signed [W-1:0] v0;
		logic signed [W-1:0] v1;
		logic signed [W-1:0] a1;
	} fctx_t;

	typedef struct packed {
		logic                kind;
		logic                degen;
		logic                sat;
		logic signed [W-1:0] lin_res;
	} octx_t;

	typedef struct packed {
		logic                kind;
		logic                degen;
		logic signed [W:0]   dq;
		logic signed [W:0]   dx;
		logic signed [W:0]   delta;
		logic signed [W-1:0] v0;
	} mid_t;

	typedef struct packed {
		logic                kind;
		logic                degen;
		logic                rneg;
		logic signed [W:0]   delta;
		logic signed [W-1:0] v0;
	} bctx_t;

	typedef struct packed {
		logic signed [W-1:0] result_value;
		logic                degenerate;
		logic                saturated;
	} out_t;

	localparam int FCTX_W = $bits(fctx_t);
	localparam int OCTX_W = $bits(octx_t);
	localparam int CTX_W  = (FCTX_W > OCTX_W) ? FCTX_W : OCTX_W;
	localparam int MID_W  = $bits(mid_t);
	localparam int OUT_W  = $bits(out_t);
	localparam int FIFO_W = (MID_W > OUT_W) ? MID_W : OUT_W;

endpackage

// File: hdl/lai_fifo.sv
// Small first-in first-out queue built from flops.
module lai_fifo (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	input  logic [lai_pkg::FIFO_W-1:0]  wdata,
	input  logic                        pop,
	output logic [lai_pkg::FIFO_W-1:0]  rdata,
	output logic                        full,
	output logic                        empty
);

	logic [lai_pkg::FIFO_W-1:0] mem_q [lai_pkg::FIFO_DEPTH];
	logic [lai_pkg::FPW-1:0]    wptr_q;
	logic [lai_pkg::FPW-1:0]    rptr_q;
	logic [lai_pkg::FCW-1:0]    cnt_q;
	logic                       do_wr;
	logic                       do_rd;

	assign full  = (cnt_q == lai_pkg::FCW'(lai_pkg::FIFO_DEPTH));
	assign empty = (cnt_q == '0);
	assign do_wr = push && !full;
	assign do_rd = pop && !empty;
	assign rdata = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_wr) begin
				wptr_q <= (wptr_q == lai_pkg::FPW'(lai_pkg::FIFO_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (do_rd) begin
				rptr_q <= (rptr_q == lai_pkg::FPW'(lai_pkg::FIFO_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// File: hdl/lai_wrap.sv
// Pipelined angle wrap to [-pi, pi): one conditional subtract of 2*pi*2^k per stage.
module lai_wrap (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             en,
	input  logic                             in_valid,
	input  logic signed [lai_pkg::WX-1:0]    x,
	input  logic [lai_pkg::CTX_W-1:0]        ctx_in,
	output logic                             out_valid,
	output logic signed [lai_pkg::W-1:0]     y,
	output logic [lai_pkg::CTX_W-1:0]        ctx_out
);

	localparam int N = lai_pkg::WSTEPS;

	logic [N:0]                  vld_s;
	logic [lai_pkg::UW-1:0]      u_s   [N+1];
	logic [lai_pkg::CTX_W-1:0]   ctx_s [N+1];
	logic [lai_pkg::UW-1:0]      diff;

	// bias so the floored modulo works on an unsigned word
	always_ff @(posedge clk) begin
		if (en) begin
			u_s[0]   <= {{(lai_pkg::UW - lai_pkg::WX){x[lai_pkg::WX-1]}}, x}
			            + lai_pkg::PI_U + lai_pkg::OFS_U;
			ctx_s[0] <= ctx_in;
		end
	end

	for (genvar g = 0; g < N; g++) begin : g_step
		localparam logic [lai_pkg::UW-1:0] SUBV = lai_pkg::TWO_PI_U << (lai_pkg::WN - g);
		always_ff @(posedge clk) begin
			if (en) begin
				u_s[g+1]   <= (u_s[g] >= SUBV) ? u_s[g] - SUBV : u_s[g];
				ctx_s[g+1] <= ctx_s[g];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[N-1:0], in_valid};
		end
	end

	assign diff      = u_s[N] - lai_pkg::PI_U;
	assign y         = $signed(diff[lai_pkg::W-1:0]);
	assign ctx_out   = ctx_s[N];
	assign out_valid = vld_s[N];

endmodule

// File: hdl/lai_div.sv
// Pipelined restoring divider for the ratio: one quotient bit per stage.
module lai_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic                         in_valid,
	input  logic [lai_pkg::DENW-1:0]     den,
	input  logic [lai_pkg::NW-1:0]       nprime,
	input  lai_pkg::bctx_t               ctx_in,
	output logic                         out_valid,
	output logic [lai_pkg::QB-1:0]       q,
	output logic                         ovf,
	output lai_pkg::bctx_t               ctx_out
);

	localparam int N = lai_pkg::QB;

	logic [N:0]                   vld_s;
	logic [lai_pkg::NW-1:0]       rem_s [N+1];
	logic [lai_pkg::DENW-1:0]     den_s [N+1];
	logic [lai_pkg::QB-1:0]       quo_s [N+1];
	logic                         ovf_s [N+1];
	lai_pkg::bctx_t               ctx_s [N+1];
	logic [lai_pkg::NW-1:0]       nhi;

	assign nhi = nprime >> lai_pkg::QB;

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= nprime;
			den_s[0] <= den;
			quo_s[0] <= '0;
			// quotient would not fit in QB bits
			ovf_s[0] <= (nhi >= {{(lai_pkg::NW - lai_pkg::DENW){1'b0}}, den});
			ctx_s[0] <= ctx_in;
		end
	end

	for (genvar g = 0; g < N; g++) begin : g_step
		localparam int K = N - 1 - g;
		logic [lai_pkg::NW-1:0] denx;
		logic [lai_pkg::NW-1:0] dsh;
		logic                   take;
		assign denx = {{(lai_pkg::NW - lai_pkg::DENW){1'b0}}, den_s[g]};
		assign dsh  = denx << K;
		assign take = ((rem_s[g] >> K) >= denx);
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[g+1] <= take ? rem_s[g] - dsh : rem_s[g];
				quo_s[g+1] <= take ? (quo_s[g] | ({{(lai_pkg::QB - 1){1'b0}}, 1'b1} << K))
				                   : quo_s[g];
				den_s[g+1] <= den_s[g];
				ovf_s[g+1] <= ovf_s[g];
				ctx_s[g+1] <= ctx_s[g];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[N-1:0], in_valid};
		end
	end

	assign out_valid = vld_s[N];
	assign q         = quo_s[N];
	assign ovf       = ovf_s[N];
	assign ctx_out   = ctx_s[N];

endmodule

// File: hdl/lai_front.sv
// Front end: input register, differences, degenerate check, angle wrap and fold.
module lai_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          push,
	input  logic                          kind,
	input  logic signed [lai_pkg::W-1:0]  start_value,
	input  logic signed [lai_pkg::W-1:0]  start_pos,
	input  logic signed [lai_pkg::W-1:0]  end_value,
	input  logic signed [lai_pkg::W-1:0]  end_pos,
	input  logic signed [lai_pkg::W-1:0]  query_pos,
	output logic                          out_valid,
	output lai_pkg::mid_t                 item
);

	logic                          vld_s1;
	logic                          kind_s1;
	logic signed [lai_pkg::W-1:0]  v0_s1;
	logic signed [lai_pkg::W-1:0]  x0_s1;
	logic signed [lai_pkg::W-1:0]  v1_s1;
	logic signed [lai_pkg::W-1:0]  x1_s1;
	logic signed [lai_pkg::W-1:0]  xq_s1;

	lai_pkg::fctx_t                fc0;
	lai_pkg::fctx_t                fc1;
	lai_pkg::fctx_t                fc2;
	logic [lai_pkg::CTX_W-1:0]     ctx1;
	logic [lai_pkg::CTX_W-1:0]     ctx2;
	logic                          vld1;
	logic signed [lai_pkg::W-1:0]  a1;
	logic signed [lai_pkg::W-1:0]  a0;
	logic signed [lai_pkg::W:0]    d;
	logic signed [lai_pkg::W:0]    dfold;
	logic signed [lai_pkg::W:0]    dlin;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= push;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			kind_s1 <= kind;
			v0_s1   <= start_value;
			x0_s1   <= start_pos;
			v1_s1   <= end_value;
			x1_s1   <= end_pos;
			xq_s1   <= query_pos;
		end
	end

	always_comb begin
		fc0.kind  = kind_s1;
		fc0.degen = (x0_s1 == x1_s1);
		fc0.dq    = $signed({xq_s1[lai_pkg::W-1], xq_s1}) - $signed({x0_s1[lai_pkg::W-1], x0_s1});
		fc0.dx    = $signed({x1_s1[lai_pkg::W-1], x1_s1}) - $signed({x0_s1[lai_pkg::W-1], x0_s1});
		fc0.v0    = v0_s1;
		fc0.v1    = v1_s1;
		fc0.a1    = '0;
	end

	// end angle first, start angle second
	lai_wrap u_wrap_end (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (vld_s1),
		.x         (lai_pkg::WX'(v1_s1)),
		.ctx_in    (lai_pkg::CTX_W'(fc0)),
		.out_valid (vld1),
		.y         (a1),
		.ctx_out   (ctx1)
	);

	always_comb begin
		fc1    = lai_pkg::fctx_t'(ctx1[lai_pkg::FCTX_W-1:0]);
		fc1.a1 = a1;
	end

	lai_wrap u_wrap_start (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (vld1),
		.x         (lai_pkg::WX'(fc1.v0)),
		.ctx_in    (lai_pkg::CTX_W'(fc1)),
		.out_valid (out_valid),
		.y         (a0),
		.ctx_out   (ctx2)
	);

	// fold the angle difference into [-pi, pi]
	always_comb begin
		fc2  = lai_pkg::fctx_t'(ctx2[lai_pkg::FCTX_W-1:0]);
		d    = $signed({fc2.a1[lai_pkg::W-1], fc2.a1}) - $signed({a0[lai_pkg::W-1], a0});
		dlin = $signed({fc2.v1[lai_pkg::W-1], fc2.v1}) - $signed({fc2.v0[lai_pkg::W-1], fc2.v0});
		if (d > lai_pkg::PI_D) begin
			dfold = d - lai_pkg::TWO_PI_D;
		end else if (d < -lai_pkg::PI_D) begin
			dfold = d + lai_pkg::TWO_PI_D;
		end else begin
			dfold = d;
		end
		item.kind  = fc2.kind;
		item.degen = fc2.degen;
		item.dq    = fc2.dq;
		item.dx    = fc2.dx;
		item.delta = fc2.kind ? dfold : dlin;
		item.v0    = fc2.v0;
	end

endmodule

// File: hdl/lai_back.sv
// Back end: ratio division, scaling, sum, saturation and final angle wrap.
module lai_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_valid,
	input  lai_pkg::mid_t   item,
	output logic            out_valid,
	output lai_pkg::out_t   res
);

	typedef struct packed {
		logic                         kind;
		logic                         degen;
		logic                         sat;
		logic                         neg;
		logic signed [lai_pkg::W-1:0] v0;
	} pctx_t;

	logic                         vld_s1;
	lai_pkg::mid_t                item_s1;
	logic [lai_pkg::W:0]          dq_abs;
	logic [lai_pkg::W:0]          dx_abs;
	logic [lai_pkg::DENW-1:0]     den;
	logic [lai_pkg::NW-1:0]       nprime;
	lai_pkg::bctx_t               bc_in;

	logic                         dvld;
	logic [lai_pkg::QB-1:0]       dq_quo;
	logic                         dovf;
	lai_pkg::bctx_t               bc_out;

	logic                         over;
	logic [lai_pkg::W-1:0]        rmag;

	logic                         vld_s2;
	logic [lai_pkg::W-1:0]        rmag_s2;
	logic signed [lai_pkg::W:0]   delta_s2;
	pctx_t                        pc_s2;
	logic [lai_pkg::W:0]          md;

	logic                         vld_s3;
	logic [lai_pkg::PLO_W-1:0]    plo_s3;
	logic [lai_pkg::PHI_W-1:0]    phi_s3;
	pctx_t                        pc_s3;

	logic                         vld_s4;
	logic [lai_pkg::PW-1:0]       p_s4;
	pctx_t                        pc_s4;
	logic [lai_pkg::PW-1:0]       pr;

	logic                         vld_s5;
	logic [lai_pkg::QW-1:0]       qr_s5;
	pctx_t                        pc_s5;
	logic signed [lai_pkg::SW-1:0] v0x;
	logic signed [lai_pkg::SW-1:0] qx;

	logic                         vld_s6;
	logic signed [lai_pkg::SW-1:0] sum_s6;
	pctx_t                        pc_s6;

	localparam logic signed [lai_pkg::SW-1:0] SMAX = lai_pkg::SW'(64'sd2147483647);
	localparam logic signed [lai_pkg::SW-1:0] SMIN = lai_pkg::SW'(-64'sd2147483648);

	logic                         lin_ovf;
	logic signed [lai_pkg::W-1:0] lin_clamp;
	logic signed [lai_pkg::WX-1:0] wx;
	lai_pkg::octx_t               oc_in;
	lai_pkg::octx_t               oc_out;
	logic [lai_pkg::CTX_W-1:0]    octx_raw;
	logic signed [lai_pkg::W-1:0] wy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= dvld;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_s1 <= item;
		end
	end

	// magnitudes; rounding bias den/2 folded into the dividend
	always_comb begin
		dq_abs = item_s1.dq[lai_pkg::W] ? $unsigned(-item_s1.dq) : $unsigned(item_s1.dq);
		dx_abs = item_s1.dx[lai_pkg::W] ? $unsigned(-item_s1.dx) : $unsigned(item_s1.dx);
		den    = dx_abs[lai_pkg::W-1:0];
		nprime = {1'b0, dq_abs[lai_pkg::W-1:0], {lai_pkg::FRAC_BITS{1'b0}}}
		         + lai_pkg::NW'(den >> 1);
		bc_in.kind  = item_s1.kind;
		bc_in.degen = item_s1.degen;
		bc_in.rneg  = item_s1.dq[lai_pkg::W] ^ item_s1.dx[lai_pkg::W];
		bc_in.delta = item_s1.delta;
		bc_in.v0    = item_s1.v0;
	end

	lai_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (vld_s1),
		.den       (den),
		.nprime    (nprime),
		.ctx_in    (bc_in),
		.out_valid (dvld),
		.q         (dq_quo),
		.ovf       (dovf),
		.ctx_out   (bc_out)
	);

	// clamp ratio magnitude to the signed word range
	always_comb begin
		if (bc_out.rneg) begin
			over = dovf || (dq_quo > lai_pkg::RMAG_NEG);
			rmag = over ? lai_pkg::RMAG_NEG[lai_pkg::W-1:0] : dq_quo[lai_pkg::W-1:0];
		end else begin
			over = dovf || (dq_quo > lai_pkg::RMAG_POS);
			rmag = over ? lai_pkg::RMAG_POS[lai_pkg::W-1:0] : dq_quo[lai_pkg::W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rmag_s2     <= rmag;
			delta_s2    <= bc_out.delta;
			pc_s2.kind  <= bc_out.kind;
			pc_s2.degen <= bc_out.degen;
			pc_s2.sat   <= over;
			pc_s2.neg   <= bc_out.delta[lai_pkg::W] ^ bc_out.rneg;
			pc_s2.v0    <= bc_out.v0;
		end
	end

	assign md = delta_s2[lai_pkg::W] ? $unsigned(-delta_s2) : $unsigned(delta_s2);

	// two partial products, summed next stage
	always_ff @(posedge clk) begin
		if (en) begin
			plo_s3 <= lai_pkg::PLO_W'(md[lai_pkg::MSPLIT-1:0]) * lai_pkg::PLO_W'(rmag_s2);
			phi_s3 <= lai_pkg::PHI_W'(md[lai_pkg::W:lai_pkg::MSPLIT]) * lai_pkg::PHI_W'(rmag_s2);
			pc_s3  <= pc_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s4  <= (lai_pkg::PW'(phi_s3) << lai_pkg::MSPLIT) + lai_pkg::PW'(plo_s3);
			pc_s4 <= pc_s3;
		end
	end

	assign pr = p_s4 + lai_pkg::HALF;

	always_ff @(posedge clk) begin
		if (en) begin
			qr_s5 <= pr[lai_pkg::PW-1:lai_pkg::FRAC_BITS];
			pc_s5 <= pc_s4;
		end
	end

	assign v0x = lai_pkg::SW'(pc_s5.v0);
	assign qx  = $signed({2'b00, qr_s5});

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s6 <= pc_s5.neg ? v0x - qx : v0x + qx;
			pc_s6  <= pc_s5;
		end
	end

	always_comb begin
		lin_ovf = 1'b0;
		if (sum_s6 > SMAX) begin
			lin_clamp = SMAX[lai_pkg::W-1:0];
			lin_ovf   = 1'b1;
		end else if (sum_s6 < SMIN) begin
			lin_clamp = SMIN[lai_pkg::W-1:0];
			lin_ovf   = 1'b1;
		end else begin
			lin_clamp = sum_s6[lai_pkg::W-1:0];
		end
		wx            = pc_s6.degen ? lai_pkg::WX'(pc_s6.v0) : $signed(sum_s6[lai_pkg::WX-1:0]);
		oc_in.kind    = pc_s6.kind;
		oc_in.degen   = pc_s6.degen;
		oc_in.sat     = pc_s6.degen ? 1'b0 : (pc_s6.sat || (!pc_s6.kind && lin_ovf));
		oc_in.lin_res = pc_s6.degen ? pc_s6.v0 : lin_clamp;
	end

	lai_wrap u_wrap_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (vld_s6),
		.x         (wx),
		.ctx_in    (lai_pkg::CTX_W'(oc_in)),
		.out_valid (out_valid),
		.y         (wy),
		.ctx_out   (octx_raw)
	);

	always_comb begin
		oc_out           = lai_pkg::octx_t'(octx_raw[lai_pkg::OCTX_W-1:0]);
		res.result_value = oc_out.kind ? wy : oc_out.lin_res;
		res.degenerate   = oc_out.degen;
		res.saturated    = oc_out.sat;
	end

endmodule

// File: hdl/linear_and_angle_interpolator.sv
// Path from an accepted push to empty going low: two angle-wrap pipelines in the front,
//   the ratio divider (input register plus 33 quotient-bit stages), five scale/sum
//   stages and the output angle-wrap pipeline in the back.
// Throughput: one item per cycle sustained while pop keeps up; the front and back
//   pipelines each advance as a whole and stall only when their downstream queue is full.
// Reset: arst_n asynchronous, active low; clears all valid flags and queue pointers.
module linear_and_angle_interpolator (
	input  logic                          clk,
	input  logic                          arst_n,
	// input queue side
	input  logic                          push,
	output logic                          full,
	input  logic                          kind,
	input  logic signed [lai_pkg::W-1:0]  start_value,
	input  logic signed [lai_pkg::W-1:0]  start_pos,
	input  logic signed [lai_pkg::W-1:0]  end_value,
	input  logic signed [lai_pkg::W-1:0]  end_pos,
	input  logic signed [lai_pkg::W-1:0]  query_pos,
	// result queue side
	output logic                          empty,
	input  logic                          pop,
	output logic signed [lai_pkg::W-1:0]  result_value,
	output logic                          degenerate,
	output logic                          saturated
);

	// front: one stall enable for the whole front pipeline, driven by the
	// middle queue filling up; an input transfer happens only when it moves
	logic                          fe;
	logic                          fr_valid;
	lai_pkg::mid_t                 fr_item;

	// middle queue between front and back
	logic                          mid_push;
	logic                          mid_pop;
	logic                          mid_full;
	logic                          mid_empty;
	logic [lai_pkg::FIFO_W-1:0]    mid_rdata;

	// back: stalls as a whole only when the result queue is full
	logic                          be;
	logic                          bk_valid;
	lai_pkg::out_t                 bk_res;
	lai_pkg::out_t                 out_item;

	logic                          out_push;
	logic                          out_full;
	logic [lai_pkg::FIFO_W-1:0]    out_rdata;

	assign fe   = !mid_full;
	assign full = mid_full;

	lai_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (fe),
		.push        (push),
		.kind        (kind),
		.start_value (start_value),
		.start_pos   (start_pos),
		.end_value   (end_value),
		.end_pos     (end_pos),
		.query_pos   (query_pos),
		.out_valid   (fr_valid),
		.item        (fr_item)
	);

	// the last front stage empties into the queue on the same edge it advances
	assign mid_push = fr_valid && fe;

	lai_fifo u_mid_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (mid_push),
		.wdata  (lai_pkg::FIFO_W'(fr_item)),
		.pop    (mid_pop),
		.rdata  (mid_rdata),
		.full   (mid_full),
		.empty  (mid_empty)
	);

	assign be      = !out_full;
	assign mid_pop = be && !mid_empty;

	lai_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (be),
		.in_valid  (!mid_empty),
		.item      (lai_pkg::mid_t'(mid_rdata[lai_pkg::MID_W-1:0])),
		.out_valid (bk_valid),
		.res       (bk_res)
	);

	assign out_push = bk_valid && be;

	// result queue decouples the back pipeline from the consumer
	lai_fifo u_out_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (out_push),
		.wdata  (lai_pkg::FIFO_W'(bk_res)),
		.pop    (pop),
		.rdata  (out_rdata),
		.full   (out_full),
		.empty  (empty)
	);

	assign out_item     = lai_pkg::out_t'(out_rdata[lai_pkg::OUT_W-1:0]);
	assign result_value = out_item.result_value;
	assign degenerate   = out_item.degenerate;
	assign saturated    = out_item.saturated;

`ifndef SYNTHESIS
	// front never pushes into a full middle queue
	a_mid_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		mid_push |-> !mid_full)
		else $error("middle queue written while full");

	// back never reads an empty middle queue
	a_mid_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		mid_pop |-> !mid_empty)
		else $error("middle queue read while empty");

	// back never pushes into a full result queue
	a_out_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		out_push |-> !out_full)
		else $error("result queue written while full");

	// equal positions never report a clamp
	a_degen_not_sat: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && degenerate) |-> !saturated)
		else $error("degenerate result flagged as saturated");
`endif

endmodule

// File: sim/tb_linear_and_angle_interpolator.sv
// Self-checking testbench for the linear and angle interpolator: directed and random traffic.
`timescale 1ns / 100ps

// Holds the expected interpolation results in arrival order and checks each popped one.
class interp_scoreboard;
	typedef struct {
		logic [31:0] value;
		logic        degen;
		logic        sat;
	} interp_res_t;

	interp_res_t pending[$];
	int          errors;

	function new();
		errors = 0;
	endfunction

	// floored wrap into [-pi, pi)
	static function longint wrap_pi(longint a);
		longint pi;
		longint r;
		pi = longint'(lai_pkg::PI_FIX64);
		r = (a + pi) % (2 * pi);
		if (r < 0)
			r += 2 * pi;
		return r - pi;
	endfunction

	// delta * ratio / 2^FRAC_BITS, rounded half away from zero
	static function longint scale_step(longint delta, longint ratio);
		logic [63:0] p;
		logic [63:0] q;
		p = (delta < 0 ? -delta : delta) * (ratio < 0 ? -ratio : ratio);
		q = (p + (64'd1 << (lai_pkg::FRAC_BITS - 1))) >> lai_pkg::FRAC_BITS;
		return ((delta < 0) != (ratio < 0)) ? -longint'(q) : longint'(q);
	endfunction

	function void note_transfer(logic kind, logic signed [31:0] v0, logic signed [31:0] x0,
			logic signed [31:0] v1, logic signed [31:0] x1, logic signed [31:0] xq);
		interp_res_t r;
		longint      res, dq, dx, ratio, a0, a1, d, pi;
		logic [63:0] num, den, qm;
		pi = longint'(lai_pkg::PI_FIX64);
		r.degen = 0;
		r.sat = 0;
		if (x0 == x1) begin
			r.degen = 1;
			res = kind ? wrap_pi(v0) : longint'(v0);
		end else begin
			dq = longint'(xq) - longint'(x0);
			dx = longint'(x1) - longint'(x0);
			den = dx < 0 ? -dx : dx;
			num = (dq < 0 ? -dq : dq) << lai_pkg::FRAC_BITS;
			qm = (num + den / 2) / den;
			if ((dq < 0) != (dx < 0)) begin
				if (qm > 64'd2147483648) begin
					ratio = -64'sd2147483648;
					r.sat = 1;
				end else
					ratio = -longint'(qm);
			end else begin
				if (qm > 64'd2147483647) begin
					ratio = 2147483647;
					r.sat = 1;
				end else
					ratio = longint'(qm);
			end
			if (kind) begin
				a0 = wrap_pi(v0);
				a1 = wrap_pi(v1);
				d = a1 - a0;
				if (d > pi)
					d -= 2 * pi;
				else if (d < -pi)
					d += 2 * pi;
				res = wrap_pi(a0 + scale_step(d, ratio));
			end else begin
				res = longint'(v0) + scale_step(longint'(v1) - longint'(v0), ratio);
				if (res > 2147483647) begin
					res = 2147483647;
					r.sat = 1;
				end else if (res < -64'sd2147483648) begin
					res = -64'sd2147483648;
					r.sat = 1;
				end
			end
		end
		r.value = res[31:0];
		pending.push_back(r);
	endfunction

	function void check_result(logic [31:0] value, logic degen, logic sat);
		interp_res_t e;
		if (pending.size() == 0) begin
			$error("result with nothing pending: %h", value);
			errors++;
			return;
		end
		e = pending.pop_front();
		if (value !== e.value) begin
			$error("result_value expected %h actual %h", e.value, value);
			errors++;
		end
		if (degen !== e.degen) begin
			$error("degenerate expected %b actual %b", e.degen, degen);
			errors++;
		end
		if (sat !== e.sat) begin
			$error("saturated expected %b actual %b", e.sat, sat);
			errors++;
		end
	endfunction
endclass

module tb_linear_and_angle_interpolator;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int DRAIN_CYCLES   = 300;

	logic                         clk;
	logic                         arst_n;
	logic                         push;
	logic                         full;
	logic                         kind;
	logic signed [lai_pkg::W-1:0] start_value;
	logic signed [lai_pkg::W-1:0] start_pos;
	logic signed [lai_pkg::W-1:0] end_value;
	logic signed [lai_pkg::W-1:0] end_pos;
	logic signed [lai_pkg::W-1:0] query_pos;
	logic                         empty;
	logic                         pop;
	logic signed [lai_pkg::W-1:0] result_value;
	logic                         degenerate;
	logic                         saturated;

	interp_scoreboard sb;
	int               idle_cycles;

	linear_and_angle_interpolator u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.kind         (kind),
		.start_value  (start_value),
		.start_pos    (start_pos),
		.end_value    (end_value),
		.end_pos      (end_pos),
		.query_pos    (query_pos),
		.empty        (empty),
		.pop          (pop),
		.result_value (result_value),
		.degenerate   (degenerate),
		.saturated    (saturated)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// Input side: one item per transfer; push held until accepted.
	task automatic send_item(logic k, logic [31:0] v0, logic [31:0] x0, logic [31:0] v1,
			logic [31:0] x1, logic [31:0] xq);
		push        <= 1'b1;
		kind        <= k;
		start_value <= v0;
		start_pos   <= x0;
		end_value   <= v1;
		end_pos     <= x1;
		query_pos   <= xq;
		@(posedge clk);
		while (full)
			@(posedge clk);
		sb.note_transfer(k, v0, x0, v1, x1, xq);
	endtask

	task automatic idle_gap(int n);
		push <= 1'b0;
		repeat (n)
			@(posedge clk);
	endtask

	// Random word: mixes full range, small values, near-pi angles and extremes.
	function automatic logic [31:0] rand_word();
		case ($urandom_range(0, 5))
			0, 1: return $urandom();
			2: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
			3: return $urandom_range(0, 32'h0007_0000) - 32'h0003_8000;
			4: return {$urandom_range(0, 1) ? 32'h7FFF_FFF0 : 32'h8000_0000} +
				$urandom_range(0, 15);
			default: return $urandom() >>> $urandom_range(0, 31);
		endcase
	endfunction

	// Mostly interpolation inside the segment, sometimes far outside or degenerate.
	task automatic send_random();
		logic [31:0] x0, x1, xq;
		x0 = rand_word();
		case ($urandom_range(0, 9))
			0: x1 = x0;
			1: x1 = x0 + $urandom_range(1, 4) * ($urandom_range(0, 1) ? 1 : -1);
			default: x1 = rand_word();
		endcase
		if ($urandom_range(0, 3) == 0)
			xq = rand_word();
		else
			xq = $signed(x0) + ($signed(x1) - $signed(x0)) / 2 + $urandom_range(0, 255) - 128;
		send_item($urandom_range(0, 1), rand_word(), x0, rand_word(), x1, xq);
	endtask

	// Result side: stall pattern changes in phases, including phases with no stall.
	initial begin
		int mode;
		pop <= 1'b0;
		@(posedge arst_n);
		forever begin
			mode = $urandom_range(0, 3);
			repeat ($urandom_range(20, 200)) begin
				@(posedge clk);
				if (!empty && pop)
					sb.check_result(result_value, degenerate, saturated);
				case (mode)
					0: pop <= 1'b1;
					1: pop <= $urandom_range(0, 1);
					2: pop <= ($urandom_range(0, 7) == 0);
					default: pop <= ($urandom_range(0, 3) != 0);
				endcase
			end
		end
	end

	// Watchdog: cycles with no transfer on either side.
	initial begin
		idle_cycles = 0;
		forever begin
			@(posedge clk);
			if ((push && !full) || (pop && !empty))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("status: fail");
				$finish;
			end
		end
	end

	initial begin
		int          wait_cycles;
		logic [31:0] pi_w;
		sb = new();
		pi_w = lai_pkg::PI_FIX64[31:0];
		arst_n      = 1'b0;
		push        = 1'b0;
		kind        = 1'b0;
		start_value = '0;
		start_pos   = '0;
		end_value   = '0;
		end_pos     = '0;
		query_pos   = '0;
		repeat (8)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: plain midpoint, degenerate both kinds, extremes, wrap corners
		send_item(1'b0, 32'h0000_0000, 32'h0000_0000, 32'h0001_0000, 32'h0001_0000,
			32'h0000_8000);
		send_item(1'b0, 32'h1234_5678, 32'h0000_1000, 32'hFFFF_0000, 32'h0000_1000,
			32'h7FFF_FFFF);
		send_item(1'b1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h8000_0000, 32'h0);
		send_item(1'b1, 32'h8000_0000, 32'h5, 32'h7FFF_FFFF, 32'h5, 32'h8000_0000);
		// ratio clamps positive and negative
		send_item(1'b0, 32'h0, 32'h0, 32'h0001_0000, 32'h1, 32'h7FFF_FFFF);
		send_item(1'b0, 32'h0, 32'h0, 32'h0001_0000, 32'h1, 32'h8000_0000);
		send_item(1'b1, 32'h0, 32'h0, 32'h0001_0000, 32'h1, 32'h8000_0000);
		// widest position span, both directions
		send_item(1'b0, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'h0);
		send_item(1'b0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
			32'h8000_0000);
		// linear result clamps high and low
		send_item(1'b0, 32'h7FFF_0000, 32'h0, 32'h7FFF_FFFF, 32'h0001_0000,
			32'h0010_0000);
		send_item(1'b0, 32'h8000_FFFF, 32'h0, 32'h8000_0000, 32'h0001_0000,
			32'h0010_0000);
		// angle: shorter way across +-pi, exact pi, just below -pi
		send_item(1'b1, pi_w - 32'h100, 32'h0, -pi_w + 32'h100, 32'h0001_0000,
			32'h0000_8000);
		send_item(1'b1, 32'h0, 32'h0, pi_w, 32'h0001_0000, 32'h0000_8000);
		send_item(1'b1, -pi_w, 32'h0, -pi_w - 32'h1, 32'h0001_0000, 32'h0003_0000);
		send_item(1'b1, 32'h7FFF_FFFF, 32'h0, 32'h8000_0000, 32'h0001_0000,
			32'hFFFF_0000);
		// rounding ties: ratio exactly half a lsb
		send_item(1'b0, 32'h0, 32'h0, 32'h1, 32'h0002_0000, 32'h1);
		send_item(1'b0, 32'h0, 32'h0, 32'hFFFF_FFFF, 32'hFFFE_0000, 32'hFFFF_FFFF);
		send_item(1'b0, 32'h5555_5555, 32'hAAAA_AAAA, 32'hAAAA_AAAA, 32'h5555_5555,
			32'hFFFF_FFFF);
		idle_gap(2);

		// random bursts with gaps, including back-to-back stretches
		repeat (700) begin
			send_random();
			if ($urandom_range(0, 7) == 0)
				idle_gap($urandom_range(1, 20));
		end
		push <= 1'b0;

		wait_cycles = 0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		while (wait_cycles < DRAIN_CYCLES) begin
			@(posedge clk);
			wait_cycles++;
		end
		if (sb.errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
